@@ design/bmpsd_pkg.sv @@
// Shared types and constants for the BMP stream decoder.
// No dependencies; imported by every design module but bmpsd_ram.
`default_nettype none
package bmpsd_pkg;

	localparam int MAX_WIDTH       = 4096;
	localparam int MAX_HEIGHT      = 4096;
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
	localparam int QDEPTH          = 4;
	localparam int QAW             = $clog2(QDEPTH);

	// header byte offsets
	localparam int HDR_OFFSET = 10;
	localparam int HDR_WIDTH  = 18;
	localparam int HDR_HEIGHT = 22;
	localparam int HDR_PLANES = 26;
	localparam int HDR_BPP    = 28;
	localparam int HDR_COMP   = 30;
	localparam int HDR_COLORS = 46;
	localparam int HDR_LAST   = 53;
	localparam int HDR_SIZE   = 54;

	localparam logic [7:0] MAGIC_B = 8'h42;
	localparam logic [7:0] MAGIC_M = 8'h4D;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PALETTE,
		PH_SKIP,
		PH_PIXEL,
		PH_PAD,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_MAGIC,
		ERR_PLANES,
		ERR_COMPRESSED,
		ERR_BPP,
		ERR_OFFSET,
		ERR_TRUNCATED
	} err_t;

	// One queue entry: optional palette write, optional pixel, optional error.
	// For a palette lookup, c0 carries the pixel's index byte.
	typedef struct packed {
		logic              pal_we;
		logic [PAL_AW-1:0] pal_addr;
		logic [23:0]       pal_data;
		logic              pix_v;
		logic              lut;
		logic              hit;
		logic [11:0]       row;
		logic [11:0]       col;
		logic [7:0]        c0;
		logic [7:0]        c1;
		logic [7:0]        c2;
		logic              done;
		logic              err_v;
		err_t              err_code;
	} qentry_t;

endpackage
`default_nettype wire

@@ design/bmpsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bmpsd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ design/bmpsd_front.sv @@
// Front end: parses the byte stream (header, palette, skip, pixels, padding)
// and pushes one work entry per byte that causes anything. Uses bmpsd_pkg.
`default_nettype none
module bmpsd_front import bmpsd_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         accept,
	input  wire  [7:0]  data_byte,
	input  wire         stream_end,
	output logic        push,
	output qentry_t     entry
);
	phase_t      phase_q, phase_n;
	logic [34:0] pos_q;
	logic [7:0]  magic_q;
	logic [31:0] off_q, hw_q, hh_q, comp_q, colors_q;
	logic [15:0] planes_q, bpp_q;
	logic [31:0] off_n, hw_n, hh_n, comp_n, colors_n;
	logic [15:0] planes_n, bpp_n;
	logic [12:0] img_w_q, img_h_q, row_q, col_q;
	logic [4:0]  bpp_img_q;
	logic [8:0]  cc_q;
	logic [34:0] pend_q;
	logic [15:0] pal_acc_q;
	logic [1:0]  bip_q, pad_q;
	logic [7:0]  pb0_q, pb1_q;

	logic [34:0] pos_next;
	err_t        hdr_err;
	phase_t      hdr_phase;
	logic [32:0] table_n;
	logic [34:0] pend_n;
	logic [8:0]  cc_n;

	logic [34:0] rel;
	logic        pal_we;

	logic [1:0]  bpb;
	logic        pix_fire;
	logic [13:0] col_inc, row_inc;
	logic        row_wrap;
	logic [1:0]  pad_amt;

	phase_t      after_pix;
	err_t        err_code;
	logic        err_v;

	function automatic phase_t choose(input logic [34:0] nxt, input logic is8,
			input logic [34:0] pend, input logic [31:0] off,
			input logic [12:0] w, input logic [12:0] h);
		phase_t r;
		if (is8 && nxt < pend)
			r = PH_PALETTE;
		else if (nxt < {3'b0, off})
			r = PH_SKIP;
		else if (w == '0 || h == '0)
			r = PH_DONE;
		else
			r = PH_PIXEL;
		return r;
	endfunction

	assign pos_next = pos_q + 35'd1;

	// header field capture
	always_comb begin
		off_n    = off_q;
		hw_n     = hw_q;
		hh_n     = hh_q;
		planes_n = planes_q;
		bpp_n    = bpp_q;
		comp_n   = comp_q;
		colors_n = colors_q;
		if (phase_q == PH_HEADER) begin
			case (pos_q)
				35'(HDR_OFFSET+0): off_n[7:0]      = data_byte;
				35'(HDR_OFFSET+1): off_n[15:8]     = data_byte;
				35'(HDR_OFFSET+2): off_n[23:16]    = data_byte;
				35'(HDR_OFFSET+3): off_n[31:24]    = data_byte;
				35'(HDR_WIDTH+0):  hw_n[7:0]       = data_byte;
				35'(HDR_WIDTH+1):  hw_n[15:8]      = data_byte;
				35'(HDR_WIDTH+2):  hw_n[23:16]     = data_byte;
				35'(HDR_WIDTH+3):  hw_n[31:24]     = data_byte;
				35'(HDR_HEIGHT+0): hh_n[7:0]       = data_byte;
				35'(HDR_HEIGHT+1): hh_n[15:8]      = data_byte;
				35'(HDR_HEIGHT+2): hh_n[23:16]     = data_byte;
				35'(HDR_HEIGHT+3): hh_n[31:24]     = data_byte;
				35'(HDR_PLANES+0): planes_n[7:0]   = data_byte;
				35'(HDR_PLANES+1): planes_n[15:8]  = data_byte;
				35'(HDR_BPP+0):    bpp_n[7:0]      = data_byte;
				35'(HDR_BPP+1):    bpp_n[15:8]     = data_byte;
				35'(HDR_COMP+0):   comp_n[7:0]     = data_byte;
				35'(HDR_COMP+1):   comp_n[15:8]    = data_byte;
				35'(HDR_COMP+2):   comp_n[23:16]   = data_byte;
				35'(HDR_COMP+3):   comp_n[31:24]   = data_byte;
				35'(HDR_COLORS+0): colors_n[7:0]   = data_byte;
				35'(HDR_COLORS+1): colors_n[15:8]  = data_byte;
				35'(HDR_COLORS+2): colors_n[23:16] = data_byte;
				35'(HDR_COLORS+3): colors_n[31:24] = data_byte;
				default: ;
			endcase
		end
	end

	// header checks and the phase that follows the header
	always_comb begin
		table_n   = (colors_q == '0) ? 33'(PALETTE_ENTRIES) : {1'b0, colors_q};
		pend_n    = (bpp_q == 16'd8) ? (35'(HDR_SIZE) + {table_n, 2'b00}) : 35'(HDR_SIZE);
		cc_n      = (table_n < 33'(PALETTE_ENTRIES)) ? table_n[8:0] : 9'(PALETTE_ENTRIES);
		if (bpp_q != 16'd8)
			cc_n = '0;
		hdr_err   = ERR_NONE;
		hdr_phase = choose(35'(HDR_SIZE), bpp_q == 16'd8, pend_n, off_q,
			hw_q[12:0], hh_q[12:0]);
		if (phase_q == PH_HEADER) begin
			if (pos_q == 35'd1 && (magic_q != MAGIC_B || data_byte != MAGIC_M))
				hdr_err = ERR_MAGIC;
			else if (pos_q == 35'(HDR_PLANES+1) && planes_n != 16'd1)
				hdr_err = ERR_PLANES;
			else if (pos_q == 35'(HDR_COMP+3) && comp_n != '0)
				hdr_err = ERR_COMPRESSED;
			else if (pos_q == 35'(HDR_LAST)) begin
				if (bpp_q != 16'd8 && bpp_q != 16'd16 && bpp_q != 16'd24)
					hdr_err = ERR_BPP;
				else if (hw_q > 32'(MAX_WIDTH) || hh_q > 32'(MAX_HEIGHT))
					hdr_err = ERR_TRUNCATED;
				else if ({3'b0, off_q} < pend_n)
					hdr_err = ERR_OFFSET;
			end
		end
	end

	// palette bytes: entries are 4 bytes, the fourth is dropped
	assign rel    = pos_q - 35'(HDR_SIZE);
	assign pal_we = (phase_q == PH_PALETTE) && (rel[1:0] == 2'd2) &&
		(rel[34:2] < {24'b0, cc_q});

	// pixel assembly
	assign bpb      = bpp_img_q[4:3];
	assign pix_fire = (phase_q == PH_PIXEL) && ((3'(bip_q) + 3'd1) >= 3'(bpb));
	assign col_inc  = 14'(col_q) + 14'd1;
	assign row_inc  = 14'(row_q) + 14'd1;
	assign row_wrap = col_inc >= 14'(img_w_q);
	assign pad_amt  = 2'd0 - 2'(img_w_q[1:0] * bpb);

	always_comb begin
		after_pix = PH_PIXEL;
		if (row_wrap) begin
			if (row_inc >= 14'(img_h_q))
				after_pix = PH_DONE;
			else if (pad_amt != 2'd0)
				after_pix = PH_PAD;
		end
	end

	// next phase (before the stream-end rearm)
	always_comb begin
		phase_n = phase_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_err != ERR_NONE)
					phase_n = PH_ERROR;
				else if (pos_q == 35'(HDR_LAST))
					phase_n = hdr_phase;
			end
			PH_PALETTE, PH_SKIP:
				phase_n = choose(pos_next, bpp_img_q == 5'd8, pend_q, off_q, img_w_q, img_h_q);
			PH_PIXEL:
				if (pix_fire)
					phase_n = after_pix;
			PH_PAD:
				if (pad_q <= 2'd1)
					phase_n = PH_PIXEL;
			PH_DONE, PH_ERROR: ;
			default: phase_n = phase_q;
		endcase
	end

	// errors to report for this byte
	always_comb begin
		err_v    = 1'b0;
		err_code = ERR_NONE;
		if (hdr_err != ERR_NONE) begin
			err_v    = 1'b1;
			err_code = hdr_err;
		end else if (stream_end && phase_n != PH_DONE && phase_n != PH_ERROR) begin
			err_v    = 1'b1;
			err_code = ERR_TRUNCATED;
		end
	end

	// queue entry
	always_comb begin
		entry          = '0;
		entry.pal_we   = pal_we;
		entry.pal_addr = rel[PAL_AW+1:2];
		entry.pal_data = {data_byte, pal_acc_q};
		entry.pix_v    = pix_fire;
		entry.row      = 12'(img_h_q - row_q - 13'd1);
		entry.col      = col_q[11:0];
		entry.done     = (row_inc == 14'(img_h_q)) && (col_inc == 14'(img_w_q));
		unique case (bpp_img_q)
			5'd24: begin
				entry.c0 = data_byte;
				entry.c1 = pb1_q;
				entry.c2 = pb0_q;
			end
			5'd16: begin
				entry.c0 = pb0_q;
				entry.c1 = data_byte;
			end
			default: begin
				entry.lut = 1'b1;
				entry.hit = {1'b0, data_byte} < cc_q;
				entry.c0  = data_byte;
			end
		endcase
		entry.err_v    = err_v;
		entry.err_code = err_code;
		push = accept && (pal_we || pix_fire || err_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			pos_q     <= '0;
			magic_q   <= '0;
			off_q     <= '0;
			hw_q      <= '0;
			hh_q      <= '0;
			planes_q  <= '0;
			bpp_q     <= '0;
			comp_q    <= '0;
			colors_q  <= '0;
			img_w_q   <= '0;
			img_h_q   <= '0;
			bpp_img_q <= '0;
			cc_q      <= '0;
			pend_q    <= '0;
			pal_acc_q <= '0;
			row_q     <= '0;
			col_q     <= '0;
			bip_q     <= '0;
			pad_q     <= '0;
			pb0_q     <= '0;
			pb1_q     <= '0;
		end else if (accept) begin
			if (stream_end) begin
				phase_q   <= PH_HEADER;
				pos_q     <= '0;
				magic_q   <= '0;
				off_q     <= '0;
				hw_q      <= '0;
				hh_q      <= '0;
				planes_q  <= '0;
				bpp_q     <= '0;
				comp_q    <= '0;
				colors_q  <= '0;
				img_w_q   <= '0;
				img_h_q   <= '0;
				bpp_img_q <= '0;
				cc_q      <= '0;
				pend_q    <= '0;
				pal_acc_q <= '0;
				row_q     <= '0;
				col_q     <= '0;
				bip_q     <= '0;
				pad_q     <= '0;
				pb0_q     <= '0;
				pb1_q     <= '0;
			end else begin
				phase_q  <= (err_v) ? PH_ERROR : phase_n;
				pos_q    <= pos_next;
				off_q    <= off_n;
				hw_q     <= hw_n;
				hh_q     <= hh_n;
				planes_q <= planes_n;
				bpp_q    <= bpp_n;
				comp_q   <= comp_n;
				colors_q <= colors_n;
				if (phase_q == PH_HEADER && pos_q == '0)
					magic_q <= data_byte;
				if (phase_q == PH_HEADER && pos_q == 35'(HDR_LAST) && hdr_err == ERR_NONE) begin
					img_w_q   <= hw_q[12:0];
					img_h_q   <= hh_q[12:0];
					bpp_img_q <= bpp_q[4:0];
					cc_q      <= cc_n;
					pend_q    <= pend_n;
				end
				if (phase_q == PH_PALETTE) begin
					if (rel[1:0] == 2'd0)
						pal_acc_q[7:0] <= data_byte;
					if (rel[1:0] == 2'd1)
						pal_acc_q[15:8] <= data_byte;
				end
				if (phase_q == PH_PIXEL) begin
					if (bip_q == 2'd0)
						pb0_q <= data_byte;
					if (bip_q == 2'd1)
						pb1_q <= data_byte;
					if (pix_fire) begin
						bip_q <= '0;
						if (row_wrap) begin
							col_q <= '0;
							row_q <= row_inc[12:0];
							pad_q <= pad_amt;
						end else begin
							col_q <= col_inc[12:0];
						end
					end else begin
						bip_q <= bip_q + 2'd1;
					end
				end
				if (phase_q == PH_PAD && pad_q != 2'd0)
					pad_q <= pad_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

@@ design/bmpsd_queue.sv @@
// Short FIFO of work entries between front and back.
// Uses bmpsd_pkg for the entry type and depth.
`default_nettype none
module bmpsd_queue import bmpsd_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         push,
	input  qentry_t     push_data,
	input  wire         pop,
	output logic        full,
	output logic        nonempty,
	output qentry_t     head
);
	qentry_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign full     = cnt_q == (QAW+1)'(QDEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

@@ design/bmpsd_back.sv @@
// Back end: applies palette writes, looks up 8 bpp pixels, and drives the
// result beats. Uses bmpsd_pkg and bmpsd_ram.
`default_nettype none
module bmpsd_back import bmpsd_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          q_nonempty,
	input  qentry_t      q_head,
	output logic         q_pop,
	output logic         out_valid,
	input  wire          out_stall,
	output logic         result_kind,
	output logic [2:0]   error_code,
	output logic [11:0]  pixel_row,
	output logic [11:0]  pixel_column,
	output logic [7:0]   chan0,
	output logic [7:0]   chan1,
	output logic [7:0]   chan2,
	output logic         frame_done,
	output logic         run_last
);
	logic        s1_v_s1;
	qentry_t     ent_s1;
	logic [23:0] pal_rd;

	logic        out_v_q, o_pix_q, o_err_q;
	logic [11:0] o_row_q, o_col_q;
	logic [7:0]  o_c0_q, o_c1_q, o_c2_q;
	logic        o_done_q;
	err_t        o_code_q;

	logic        out_take, out_free, s1_adv;
	logic [23:0] lut_val;

	bmpsd_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES)) u_pal (
		.clk   (clk),
		.we    (q_pop && q_head.pal_we),
		.waddr (q_head.pal_addr),
		.wdata (q_head.pal_data),
		.re    (q_pop && q_head.lut),
		.raddr (q_head.c0[PAL_AW-1:0]),
		.rdata (pal_rd)
	);

	assign out_take = out_v_q && !out_stall;
	// a pixel followed by an error needs two beats
	assign out_free = !out_v_q || (out_take && !(o_pix_q && o_err_q));
	assign s1_adv   = s1_v_s1 && out_free;
	assign q_pop    = q_nonempty && (!s1_v_s1 || s1_adv);
	assign lut_val  = ent_s1.hit ? pal_rd : 24'd0;

	always_ff @(posedge clk) begin
		if (q_pop)
			ent_s1 <= q_head;
		if (s1_adv) begin
			o_row_q  <= ent_s1.row;
			o_col_q  <= ent_s1.col;
			o_done_q <= ent_s1.done;
			o_code_q <= ent_s1.err_code;
			if (ent_s1.lut) begin
				o_c0_q <= lut_val[7:0];
				o_c1_q <= lut_val[15:8];
				o_c2_q <= lut_val[23:16];
			end else begin
				o_c0_q <= ent_s1.c0;
				o_c1_q <= ent_s1.c1;
				o_c2_q <= ent_s1.c2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
			o_pix_q <= 1'b0;
			o_err_q <= 1'b0;
		end else begin
			if (q_pop)
				s1_v_s1 <= q_head.pix_v || q_head.err_v;
			else if (s1_adv)
				s1_v_s1 <= 1'b0;
			if (s1_adv) begin
				out_v_q <= 1'b1;
				o_pix_q <= ent_s1.pix_v;
				o_err_q <= ent_s1.err_v;
			end else if (out_take) begin
				if (o_pix_q && o_err_q)
					o_pix_q <= 1'b0;
				else
					out_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		out_valid   = out_v_q;
		result_kind = !o_pix_q;
		run_last    = !(o_pix_q && o_err_q);
		if (o_pix_q) begin
			error_code   = ERR_NONE;
			pixel_row    = o_row_q;
			pixel_column = o_col_q;
			chan0        = o_c0_q;
			chan1        = o_c1_q;
			chan2        = o_c2_q;
			frame_done   = o_done_q;
		end else begin
			error_code   = o_code_q;
			pixel_row    = '0;
			pixel_column = '0;
			chan0        = '0;
			chan1        = '0;
			chan2        = '0;
			frame_done   = 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ design/bmp_stream_decoder_unit.sv @@
// Top level of the BMP stream decoder: front parser, work queue, back end.
// Uses bmpsd_pkg, bmpsd_front, bmpsd_queue, bmpsd_back.
`default_nettype none
// Takes one file byte per clock while in_stall is low (data_byte,
// stream_end on the last byte) and emits pixel beats (24, 16 and 8 bpp
// with palette lookup) and coded error beats. A byte yields at most two
// beats (a pixel and an early-end error), and the output register sends
// one beat per cycle while out_stall is low, so such a pair leaves it as
// two beats in turn. A four-entry queue between parser and output lets
// the input run while the output is stalled; in_stall rises only when
// that queue is full. With no stalls a beat passes from its byte through
// the queue, then the stage that reads the palette RAM, then the output
// register, for every bpp.
module bmp_stream_decoder_unit import bmpsd_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         stream_end,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        result_kind,
	output logic [2:0]  error_code,
	output logic [11:0] pixel_row,
	output logic [11:0] pixel_column,
	output logic [7:0]  chan0,
	output logic [7:0]  chan1,
	output logic [7:0]  chan2,
	output logic        frame_done,
	output logic        run_last
);
	logic    q_full, q_nonempty, q_push, q_pop;
	qentry_t q_in, q_head;

	assign in_stall = q_full;

	bmpsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_valid && !q_full),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.push       (q_push),
		.entry      (q_in)
	);

	bmpsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	bmpsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_nonempty   (q_nonempty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.error_code   (error_code),
		.pixel_row    (pixel_row),
		.pixel_column (pixel_column),
		.chan0        (chan0),
		.chan1        (chan1),
		.chan2        (chan2),
		.frame_done   (frame_done),
		.run_last     (run_last)
	);
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for bmp_stream_decoder_unit: directed and random BMP streams in,
// predicted pixel and error beats compared field by field on the way out.
// Depends on bmpsd_pkg and the design sources.
`default_nettype none
module testbench;
	import bmpsd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic KIND_PIXEL = 1'b0;
	localparam logic KIND_ERROR = 1'b1;
	localparam int   ITEM_TARGET = 1950;
	localparam int   IDLE_LIMIT  = 5000;
	localparam int   HOLD_CYCLES = 300;
	localparam int   DRAIN_WAIT  = 40;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} in_beat_t;

	typedef struct {
		logic        kind;
		logic [2:0]  code;
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  c0, c1, c2;
		logic        done;
		logic        last;
	} out_beat_t;

	logic        clk, arst_n;
	logic        in_valid, in_stall, stream_end, out_valid, out_stall;
	logic [7:0]  data_byte;
	logic        result_kind, frame_done, run_last;
	logic [2:0]  error_code;
	logic [11:0] pixel_row, pixel_column;
	logic [7:0]  chan0, chan1, chan2;

	bmp_stream_decoder_unit dut (.*);

	in_beat_t  byte_q[$];
	out_beat_t beat_q[$];
	int        fail_cnt = 0;
	int        sent = 0;
	bit        stim_done = 0;

	// ---------------- decoder prediction ----------------
	phase_t           ph;
	longint unsigned  pos, pal_end;
	logic [7:0]       magic0;
	int unsigned      h_off, h_w, h_h, h_planes, h_bpp, h_comp, h_cols;
	int unsigned      img_w, img_h, img_bpp, n_cols;
	logic [23:0]      pal[256];
	int unsigned      rows_seen, cols_seen, sub_byte, pad_left;
	logic [7:0]       px[3];

	function automatic int unsigned take_le(int unsigned v, longint unsigned p,
			int base, int len, logic [7:0] b);
		if (p >= base && p < base + len)
			v |= int'(b) << (8 * (p - base));
		return v;
	endfunction

	function void clear_decoder();
		ph = PH_HEADER;
		pos = 0; pal_end = 0; magic0 = 0;
		{h_off, h_w, h_h, h_planes, h_bpp, h_comp, h_cols} = '0;
		{img_w, img_h, img_bpp, n_cols} = '0;
		foreach (pal[i]) pal[i] = '0;
		{rows_seen, cols_seen, sub_byte, pad_left} = '0;
		foreach (px[i]) px[i] = '0;
	endfunction

	function void next_region(longint unsigned nxt);
		if (img_bpp == 8 && nxt < pal_end) ph = PH_PALETTE;
		else if (nxt < h_off) ph = PH_SKIP;
		else if (img_w == 0 || img_h == 0) ph = PH_DONE;
		else ph = PH_PIXEL;
	endfunction

	function void push_beat(logic kind, logic [2:0] code, int unsigned row,
			int unsigned col, logic [7:0] c0, c1, c2, logic done);
		out_beat_t e;
		e.kind = kind; e.code = code; e.row = row[11:0]; e.col = col[11:0];
		e.c0 = c0; e.c1 = c1; e.c2 = c2; e.done = done; e.last = 0;
		beat_q.push_back(e);
	endfunction

	function void decode_byte(logic [7:0] b, logic fin);
		int          n;
		err_t        err;
		longint unsigned ncol, rel;
		int unsigned bpb, pad, e;
		logic [7:0]  c0, c1, c2;
		logic        done;
		n = beat_q.size();
		err = ERR_NONE;
		case (ph)
			PH_HEADER: begin
				if (pos == 0) magic0 = b;
				h_off    = take_le(h_off, pos, HDR_OFFSET, 4, b);
				h_w      = take_le(h_w, pos, HDR_WIDTH, 4, b);
				h_h      = take_le(h_h, pos, HDR_HEIGHT, 4, b);
				h_planes = take_le(h_planes, pos, HDR_PLANES, 2, b);
				h_bpp    = take_le(h_bpp, pos, HDR_BPP, 2, b);
				h_comp   = take_le(h_comp, pos, HDR_COMP, 4, b);
				h_cols   = take_le(h_cols, pos, HDR_COLORS, 4, b);
				if (pos == 1 && (magic0 != MAGIC_B || b != MAGIC_M)) err = ERR_MAGIC;
				else if (pos == 27 && h_planes != 1) err = ERR_PLANES;
				else if (pos == 33 && h_comp != 0) err = ERR_COMPRESSED;
				else if (pos == HDR_LAST) begin
					ncol = (h_cols == 0) ? 256 : h_cols;
					if (h_bpp != 8 && h_bpp != 16 && h_bpp != 24) err = ERR_BPP;
					else if (h_w > MAX_WIDTH || h_h > MAX_HEIGHT) err = ERR_TRUNCATED;
					else begin
						img_bpp = h_bpp; img_w = h_w; img_h = h_h;
						pal_end = (h_bpp == 8) ? HDR_SIZE + 4 * ncol : HDR_SIZE;
						n_cols = (h_bpp == 8) ?
							((ncol < PALETTE_ENTRIES) ? ncol : PALETTE_ENTRIES) : 0;
						if (longint'(h_off) < pal_end) err = ERR_OFFSET;
						else next_region(HDR_SIZE);
					end
				end
			end
			PH_PALETTE: begin
				rel = pos - HDR_SIZE;
				if ((rel >> 2) < n_cols && (rel & 3) < 3)
					pal[rel >> 2] |= 24'(b) << (8 * (rel & 3));
				next_region(pos + 1);
			end
			PH_SKIP: next_region(pos + 1);
			PH_PIXEL: begin
				bpb = img_bpp / 8;
				px[(sub_byte < 3) ? sub_byte : 0] = b;
				sub_byte++;
				if (sub_byte >= bpb) begin
					done = (rows_seen + 1 == img_h) && (cols_seen + 1 == img_w);
					if (img_bpp == 24) begin
						c0 = px[2]; c1 = px[1]; c2 = px[0];
					end else if (img_bpp == 8) begin
						e = (px[0] < n_cols) ? pal[px[0]] : 0;
						c0 = e[7:0]; c1 = e[15:8]; c2 = e[23:16];
					end else begin
						c0 = px[0]; c1 = px[1]; c2 = 0;
					end
					push_beat(KIND_PIXEL, ERR_NONE, img_h - rows_seen - 1, cols_seen,
						c0, c1, c2, done);
					sub_byte = 0;
					cols_seen++;
					if (cols_seen >= img_w) begin
						pad = (4 - ((img_w * bpb) & 3)) & 3;
						cols_seen = 0;
						rows_seen++;
						if (rows_seen >= img_h) ph = PH_DONE;
						else if (pad != 0) begin
							pad_left = pad;
							ph = PH_PAD;
						end
					end
				end
			end
			PH_PAD: begin
				if (pad_left > 0) pad_left--;
				if (pad_left == 0) ph = PH_PIXEL;
			end
			default: ;
		endcase
		if (err != ERR_NONE) begin
			push_beat(KIND_ERROR, err, 0, 0, 0, 0, 0, 0);
			ph = PH_ERROR;
		end
		pos++;
		if (fin) begin
			if (ph != PH_DONE && ph != PH_ERROR)
				push_beat(KIND_ERROR, ERR_TRUNCATED, 0, 0, 0, 0, 0, 0);
			clear_decoder();
		end
		if (beat_q.size() > n) beat_q[beat_q.size() - 1].last = 1;
	endfunction

	// ---------------- stream generation ----------------
	// off_adj shifts the pixel offset from the end of header/palette;
	// cut >= 0 ends the stream early at that byte count (at least one byte).
	task automatic make_file(int unsigned bpp, int unsigned w, int unsigned h,
			int unsigned cols, int unsigned planes, int unsigned comp,
			int off_adj, int cut, int tail, bit bad_magic);
		logic [7:0]  f[$];
		int unsigned ncol, pend, off, bpb, rowb;
		for (int i = 0; i < HDR_SIZE; i++) f.push_back($urandom_range(0, 255));
		f[0] = MAGIC_B; f[1] = MAGIC_M;
		if (bad_magic) begin
			if ($urandom_range(0, 1)) f[0] = MAGIC_B ^ (8'h1 << $urandom_range(0, 7));
			else f[1] = MAGIC_M ^ (8'h1 << $urandom_range(0, 7));
		end
		ncol = (cols == 0) ? 256 : cols;
		pend = HDR_SIZE + ((bpp == 8) ? 4 * ncol : 0);
		off = pend + off_adj;
		for (int i = 0; i < 4; i++) begin
			f[HDR_OFFSET + i] = off >> (8 * i);
			f[HDR_WIDTH + i]  = w >> (8 * i);
			f[HDR_HEIGHT + i] = h >> (8 * i);
			f[HDR_COMP + i]   = comp >> (8 * i);
			f[HDR_COLORS + i] = cols >> (8 * i);
		end
		for (int i = 0; i < 2; i++) begin
			f[HDR_PLANES + i] = planes >> (8 * i);
			f[HDR_BPP + i]    = bpp >> (8 * i);
		end
		if (bpp == 8 && ncol <= 256)
			for (int i = 0; i < 4 * ncol; i++) f.push_back($urandom_range(0, 255));
		for (int i = pend; i < off && i < pend + 64; i++) f.push_back($urandom_range(0, 255));
		bpb = (bpp >= 8 && bpp <= 24) ? bpp / 8 : 1;
		rowb = (w * bpb + 3) & ~3;
		if (w <= 64 && h <= 64 && rowb * h <= 3000)
			for (int r = 0; r < h; r++)
				for (int i = 0; i < rowb; i++)
					f.push_back((bpp == 8 && i < w) ?
						$urandom_range(0, (ncol + 1 > 255) ? 255 : ncol + 1) :
						$urandom_range(0, 255));
		for (int i = 0; i < tail; i++) f.push_back($urandom_range(0, 255));
		if (cut >= 0) while (f.size() > ((cut < 1) ? 1 : cut)) void'(f.pop_back());
		foreach (f[i]) byte_q.push_back('{data: f[i], last: (i == f.size() - 1)});
	endtask

	task automatic make_noise(int len);
		for (int i = 0; i < len; i++)
			byte_q.push_back('{data: $urandom_range(0, 255), last: (i == len - 1)});
	endtask

	function automatic int unsigned pick_bpp();
		case ($urandom_range(0, 2))
			0: return 8;
			1: return 16;
			default: return 24;
		endcase
	endfunction

	task automatic make_random_file();
		int unsigned k, bpp;
		k = $urandom_range(0, 99);
		bpp = pick_bpp();
		if (k < 75)
			make_file(bpp, $urandom_range(1, 5), $urandom_range(1, 4),
				$urandom_range(1, 6), 1, 0, $urandom_range(0, 1) ? 0 : $urandom_range(1, 5),
				-1, $urandom_range(0, 1) ? 0 : $urandom_range(1, 4), 0);
		else if (k < 85) // stream cut short somewhere
			make_file(bpp, $urandom_range(1, 4), $urandom_range(1, 3),
				$urandom_range(1, 4), 1, 0, 0, $urandom_range(1, 90), 0, 0);
		else if (k < 95) begin
			case ($urandom_range(0, 5))
				0: make_file(bpp, 2, 2, 2, 1, 0, 0, -1, 0, 1);
				1: make_file(bpp, 2, 2, 2, $urandom_range(2, 65535), 0, 0, -1, 0, 0);
				2: make_file(bpp, 2, 2, 2, 1, $urandom, 0, -1, 0, 0);
				3: make_file($urandom_range(25, 65535), 2, 2, 2, 1, 0, 0, -1, 0, 0);
				4: make_file(bpp, $urandom_range(4097, 32'hFFFF_FFFF), 1, 2, 1, 0, 0, -1, 0, 0);
				default: make_file(bpp, 2, 2, 2, 1, 0, -$urandom_range(1, 20), -1, 0, 0);
			endcase
		end else
			make_noise($urandom_range(1, 40));
	endtask

	// ---------------- clock, reset, stimulus ----------------
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		// directed: corners, each error, palette and bpp special cases
		make_file(24, 1, 1, 0, 1, 0, 0, -1, 0, 0);
		make_file(16, 3, 2, 0, 1, 0, 2, -1, 3, 0);
		make_file(8, 3, 2, 3, 1, 0, 0, -1, 0, 0);
		make_file(8, 2, 1, 0, 1, 0, 0, -1, 0, 0);      // zero count: 256-entry table
		make_file(8, 2, 2, 300, 1, 0, 0, -1, 0, 0);    // more entries than stored
		make_file(24, 0, 3, 0, 1, 0, 0, -1, 2, 0);     // empty image
		make_file(16, 4096, 0, 0, 1, 0, 0, -1, 0, 0);
		make_file(24, 1, 4096, 0, 1, 0, 0, 60, 0, 0);
		make_file(24, 2, 2, 0, 1, 0, 0, -1, 0, 1);
		make_file(24, 2, 2, 0, 0, 0, 0, -1, 0, 0);
		make_file(24, 2, 2, 0, 1, 1, 0, -1, 0, 0);
		make_file(32, 2, 2, 0, 1, 0, 0, -1, 0, 0);
		make_file(24, 4097, 1, 0, 1, 0, 0, -1, 0, 0);
		make_file(8, 2, 2, 4, 1, 0, -1, -1, 0, 0);
		make_file(24, 3, 3, 0, 1, 0, 0, 70, 0, 0);
		make_noise(1);
		make_noise(2);
		while (byte_q.size() < ITEM_TARGET) make_random_file();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		wait (byte_q.size() == 0 && !in_valid);
		stim_done = 1;
		wait (beat_q.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_cnt == 0 && beat_q.size() == 0)
			$display("bmp_stream_decoder_unit verification clean");
		else
			$display("bmp_stream_decoder_unit verification failed");
		$finish;
	end

	// ---------------- sender ----------------
	int  gap_left;
	bit  calm_in;
	initial clear_decoder();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0; data_byte <= 0; stream_end <= 0;
			gap_left = 0; calm_in = 0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_byte(data_byte, stream_end);
				sent++;
			end
			if (!in_valid || !in_stall) begin
				if ($urandom_range(0, 199) == 0) calm_in = !calm_in;
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 0;
				end else if (byte_q.size() > 0) begin
					in_beat_t nb;
					nb = byte_q.pop_front();
					in_valid <= 1; data_byte <= nb.data; stream_end <= nb.last;
					if (!calm_in)
						case ($urandom_range(0, 19))
							0, 1, 2: gap_left = $urandom_range(1, 3);
							3: gap_left = $urandom_range(8, 30);
							default: gap_left = 0;
						endcase
				end else
					in_valid <= 0;
			end
		end
	end

	// ---------------- receiver and checker ----------------
	int  stall_left, hold_left;
	bit  held, calm_out;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
			stall_left = 0; hold_left = 0; held = 0; calm_out = 0;
		end else begin
			if ($urandom_range(0, 149) == 0) calm_out = !calm_out;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1;
			end else if (!held && sent >= 600) begin
				// long back-pressure while the sender keeps offering bytes
				held = 1;
				hold_left = HOLD_CYCLES;
				out_stall <= 1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1;
			end else if (!calm_out && $urandom_range(0, 9) < 3) begin
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
					: $urandom_range(0, 2);
				out_stall <= 1;
			end else
				out_stall <= 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (beat_q.size() == 0) begin
				$error("unexpected beat: kind %0d code %0d", result_kind, error_code);
				fail_cnt++;
			end else begin
				out_beat_t e;
				e = beat_q.pop_front();
				if (result_kind !== e.kind) begin
					$error("result_kind exp %0d got %0d", e.kind, result_kind); fail_cnt++;
				end
				if (error_code !== e.code) begin
					$error("error_code exp %0d got %0d", e.code, error_code); fail_cnt++;
				end
				if (pixel_row !== e.row) begin
					$error("pixel_row exp %0d got %0d", e.row, pixel_row); fail_cnt++;
				end
				if (pixel_column !== e.col) begin
					$error("pixel_column exp %0d got %0d", e.col, pixel_column); fail_cnt++;
				end
				if (chan0 !== e.c0) begin
					$error("chan0 exp %0h got %0h", e.c0, chan0); fail_cnt++;
				end
				if (chan1 !== e.c1) begin
					$error("chan1 exp %0h got %0h", e.c1, chan1); fail_cnt++;
				end
				if (chan2 !== e.c2) begin
					$error("chan2 exp %0h got %0h", e.c2, chan2); fail_cnt++;
				end
				if (frame_done !== e.done) begin
					$error("frame_done exp %0d got %0d", e.done, frame_done); fail_cnt++;
				end
				if (run_last !== e.last) begin
					$error("run_last exp %0d got %0d", e.last, run_last); fail_cnt++;
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || stim_done
				&& beat_q.size() == 0)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("bmp_stream_decoder_unit verification failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
`default_nettype wire
